// ----- rtl/core/thread_slot_round_robin_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// thread slot scheduler assertion macros
// shared property wrappers, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef THREAD_SLOT_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define THREAD_SLOT_ROUND_ROBIN_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define TSRR_ASSERT_IMP(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSRR_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tsrr_pkg.sv -----
// ----------------------------------------------------------------------------
// tsrr_pkg
// types and constants shared by the thread slot scheduler modules
// ----------------------------------------------------------------------------
`default_nettype none

package tsrr_pkg;

  localparam int THREAD_SLOTS_DEF = 16;
  localparam int CPU_COUNT_DEF    = 4;

  localparam int RATE_W      = 14;
  localparam logic [RATE_W-1:0] RATE_RESET = 14'd100;

  // ceil(ms * rate / 1000) by folding: x = h * 1024 + l = h * 1000 + (24 * h + l)
  localparam int PROD_W  = 46;
  localparam int DIV_N_W = 47;
  localparam int DIV_SH  = 10;
  localparam int DIV_H_W = DIV_N_W - DIV_SH;
  localparam logic [DIV_SH-1:0]  DIVISOR  = 10'd1000;
  localparam logic [DIV_N_W-1:0] ROUND_UP = 47'd999;

  // pinned cpu code for "any"
  localparam logic [2:0] PIN_ANY = 3'b100;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_YIELD  = 3'd2,
    ACT_SLEEP  = 3'd3,
    ACT_EXIT   = 3'd4,
    ACT_REAP   = 3'd5,
    ACT_ADOPT  = 3'd6
  } act_t;

  localparam logic [2:0] ACT_CODE_BAD = 3'd7;

  typedef enum logic [1:0] {
    STAT_SWITCHED = 2'd0,
    STAT_NONE     = 2'd1,
    STAT_REJECT   = 2'd2,
    STAT_DONE     = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    SS_FREE     = 3'd0,
    SS_READY    = 3'd1,
    SS_RUNNING  = 3'd2,
    SS_SLEEPING = 3'd3,
    SS_DEAD     = 3'd4
  } sstate_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DECODE,
    PH_MUL,
    PH_DIV,
    PH_SLEEP_WR,
    PH_SCAN,
    PH_RELEASE,
    PH_TICK
  } phase_t;

  // one classified action travelling from front to back
  typedef struct packed {
    act_t        act;
    logic        rej;
    logic [1:0]  cpu;
    logic [3:0]  slot;
    logic [2:0]  pin;
    logic [31:0] now;
    logic [31:0] ms;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/core/tsrr_front.sv -----
// ----------------------------------------------------------------------------
// tsrr_front
// accepts actions, checks ranges and codes, and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module tsrr_front #(
  parameter int THREAD_SLOTS = tsrr_pkg::THREAD_SLOTS_DEF,
  parameter int CPU_COUNT    = tsrr_pkg::CPU_COUNT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          action,
  input  wire logic [1:0]          cpu,
  input  wire logic [3:0]          slot,
  input  wire logic signed [2:0]   pin_cpu,
  input  wire logic [31:0]         now_tick,
  input  wire logic [31:0]         sleep_ms,
  output logic                     q_valid,
  output tsrr_pkg::item_t          q_item,
  input  wire logic                pop
);

  tsrr_pkg::item_t mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       bad_code;
  logic       needs_cpu;
  logic       needs_slot;
  tsrr_pkg::item_t cls;

  // classify the incoming action
  always_comb begin
    bad_code   = (action == tsrr_pkg::ACT_CODE_BAD);
    needs_cpu  = (action == tsrr_pkg::ACT_YIELD) || (action == tsrr_pkg::ACT_SLEEP) ||
                 (action == tsrr_pkg::ACT_EXIT)  || (action == tsrr_pkg::ACT_ADOPT);
    needs_slot = (action == tsrr_pkg::ACT_CREATE) || (action == tsrr_pkg::ACT_REAP) ||
                 (action == tsrr_pkg::ACT_ADOPT);
    cls.act = bad_code ? tsrr_pkg::ACT_TICK : tsrr_pkg::act_t'(action);
    cls.rej = bad_code || (needs_cpu && (int'(cpu) >= CPU_COUNT)) ||
              (needs_slot && (int'(slot) >= THREAD_SLOTS));
    cls.cpu  = cpu;
    cls.slot = slot;
    cls.pin  = pin_cpu[2] ? tsrr_pkg::PIN_ANY : pin_cpu;
    cls.now  = now_tick;
    cls.ms   = sleep_ms;
  end

  // two-entry queue
  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/tsrr_back.sv -----
// ----------------------------------------------------------------------------
// tsrr_back
// slot table, per-cpu current slot, round-robin scan and sleep divider
// ----------------------------------------------------------------------------
`default_nettype none

`include "thread_slot_round_robin_scheduler_defines.svh"

module tsrr_back #(
  parameter int THREAD_SLOTS = tsrr_pkg::THREAD_SLOTS_DEF,
  parameter int CPU_COUNT    = tsrr_pkg::CPU_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  input  wire tsrr_pkg::item_t             q_item,
  output logic                             pop,
  input  wire logic [tsrr_pkg::RATE_W-1:0] rate,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       status,
  output logic [3:0]                       chosen_slot,
  output logic [3:0]                       previous_slot,
  output logic [4:0]                       woken_count
);

  localparam int SW = $clog2(THREAD_SLOTS);
  localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int NW = $clog2(THREAD_SLOTS + 1);
  localparam logic [SW-1:0] LAST = SW'(THREAD_SLOTS - 1);

  // slot table
  tsrr_pkg::sstate_t st_tab [THREAD_SLOTS];
  logic [31:0]       wake_tab [THREAD_SLOTS];
  logic              runv_tab [THREAD_SLOTS];
  logic [CW-1:0]     runc_tab [THREAD_SLOTS];
  logic [2:0]        pin_tab [THREAD_SLOTS];

  // per-cpu current slot
  logic          cur_v [CPU_COUNT];
  logic [SW-1:0] cur_idx [CPU_COUNT];

  tsrr_pkg::phase_t phase, phase_next;
  tsrr_pkg::item_t  it;
  logic [31:0]      last_now;
  logic             prev_v;
  logic [SW-1:0]    prev_s;
  logic [SW-1:0]    scan_i;
  logic [SW-1:0]    scan_n;
  logic [NW-1:0]    woken;

  logic [tsrr_pkg::DIV_N_W-1:0] div_x;
  logic [31:0]                  div_q;
  logic [tsrr_pkg::PROD_W-1:0]  prod;
  logic [tsrr_pkg::DIV_H_W-1:0] div_h;
  logic                         div_done;
  logic                         div_fix;

  tsrr_pkg::stat_t res_status;
  logic            res_clear;

  // decode helpers
  logic [CW-1:0]     ci;
  logic [SW-1:0]     slot_i;
  logic              cur_vc;
  logic [SW-1:0]     cur_sc;
  logic [SW-1:0]     start_i;
  logic              uses_slot;
  logic [SW-1:0]     rd_a;
  tsrr_pkg::sstate_t r_st;
  logic [31:0]       r_wake;
  logic              r_runv;
  logic [CW-1:0]     r_runc;
  logic [2:0]        r_pin;
  logic              may_run;
  logic              last_step;
  logic              self_hit;
  logic              wake_hit;
  logic [3:0]        prev_out;

  // control outputs
  logic              we;
  tsrr_pkg::sstate_t w_st;
  logic [31:0]       w_wake;
  logic              w_runv;
  logic [CW-1:0]     w_runc;
  logic [2:0]        w_pin;
  logic              cur_we;
  logic [SW-1:0]     cur_wi;
  logic              res_load;
  tsrr_pkg::stat_t   res_st;
  logic [3:0]        res_ch;
  logic [3:0]        res_pr;
  logic [4:0]        res_wk;

  // table read port, shared by all phases
  always_comb begin
    ci        = CW'(it.cpu);
    slot_i    = SW'(it.slot);
    cur_vc    = cur_v[ci];
    cur_sc    = cur_idx[ci];
    start_i   = (cur_vc && (cur_sc != LAST)) ? cur_sc + 1'b1 : '0;
    uses_slot = (it.act == tsrr_pkg::ACT_CREATE) || (it.act == tsrr_pkg::ACT_REAP) ||
                (it.act == tsrr_pkg::ACT_ADOPT);
    unique case (phase)
      tsrr_pkg::PH_DECODE:                  rd_a = uses_slot ? slot_i : cur_sc;
      tsrr_pkg::PH_SCAN, tsrr_pkg::PH_TICK: rd_a = scan_i;
      default:                              rd_a = prev_s;
    endcase
    r_st      = st_tab[rd_a];
    r_wake    = wake_tab[rd_a];
    r_runv    = runv_tab[rd_a];
    r_runc    = runc_tab[rd_a];
    r_pin     = pin_tab[rd_a];
    may_run   = (r_st == tsrr_pkg::SS_READY) && !r_runv &&
                (r_pin[2] || (r_pin == {1'b0, it.cpu}));
    last_step = (scan_n == LAST);
    self_hit  = prev_v && (scan_i == prev_s);
    wake_hit  = (r_st == tsrr_pkg::SS_SLEEPING) && (it.now >= r_wake);
    prev_out  = prev_v ? 4'(prev_s) : 4'd0;
    prod      = it.ms * rate;
    // high part folds into the quotient, remainder check once it is empty
    div_h     = div_x[tsrr_pkg::DIV_N_W-1:tsrr_pkg::DIV_SH];
    div_done  = (div_h == '0);
    div_fix   = (div_x[tsrr_pkg::DIV_SH-1:0] >= tsrr_pkg::DIVISOR);
  end

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      tsrr_pkg::PH_IDLE: begin
        if (q_valid && !out_valid) phase_next = tsrr_pkg::PH_DECODE;
      end
      tsrr_pkg::PH_DECODE: begin
        phase_next = tsrr_pkg::PH_IDLE;
        if (!it.rej) begin
          unique case (it.act)
            tsrr_pkg::ACT_TICK:  phase_next = tsrr_pkg::PH_TICK;
            tsrr_pkg::ACT_YIELD: phase_next = tsrr_pkg::PH_SCAN;
            tsrr_pkg::ACT_SLEEP: begin
              if (cur_vc && (r_st == tsrr_pkg::SS_RUNNING)) phase_next = tsrr_pkg::PH_MUL;
            end
            tsrr_pkg::ACT_EXIT: begin
              if (cur_vc && (r_st == tsrr_pkg::SS_RUNNING)) phase_next = tsrr_pkg::PH_SCAN;
            end
            tsrr_pkg::ACT_ADOPT: begin
              if (may_run && cur_vc) phase_next = tsrr_pkg::PH_RELEASE;
            end
            default: phase_next = tsrr_pkg::PH_IDLE;
          endcase
        end
      end
      tsrr_pkg::PH_MUL:      phase_next = tsrr_pkg::PH_DIV;
      tsrr_pkg::PH_DIV: begin
        if (div_done) phase_next = tsrr_pkg::PH_SLEEP_WR;
      end
      tsrr_pkg::PH_SLEEP_WR: phase_next = tsrr_pkg::PH_SCAN;
      tsrr_pkg::PH_SCAN: begin
        if (may_run) begin
          phase_next = (!self_hit && prev_v) ? tsrr_pkg::PH_RELEASE : tsrr_pkg::PH_IDLE;
        end else if (last_step) begin
          phase_next = tsrr_pkg::PH_IDLE;
        end
      end
      tsrr_pkg::PH_RELEASE: phase_next = tsrr_pkg::PH_IDLE;
      tsrr_pkg::PH_TICK: begin
        if (last_step) phase_next = tsrr_pkg::PH_IDLE;
      end
      default: phase_next = tsrr_pkg::PH_IDLE;
    endcase
  end

  // table writes and result
  always_comb begin
    pop      = 1'b0;
    we       = 1'b0;
    w_st     = r_st;
    w_wake   = r_wake;
    w_runv   = r_runv;
    w_runc   = r_runc;
    w_pin    = r_pin;
    cur_we   = 1'b0;
    cur_wi   = slot_i;
    res_load = 1'b0;
    res_st   = tsrr_pkg::STAT_REJECT;
    res_ch   = 4'd0;
    res_pr   = 4'd0;
    res_wk   = 5'd0;
    unique case (phase)
      tsrr_pkg::PH_IDLE: begin
        pop = q_valid && !out_valid;
      end
      tsrr_pkg::PH_DECODE: begin
        // rejects load the default result
        res_load = 1'b1;
        if (!it.rej) begin
          unique case (it.act)
            tsrr_pkg::ACT_TICK:  res_load = 1'b0;
            tsrr_pkg::ACT_YIELD: res_load = 1'b0;
            tsrr_pkg::ACT_CREATE: begin
              if (r_st == tsrr_pkg::SS_FREE) begin
                we     = 1'b1;
                w_st   = tsrr_pkg::SS_READY;
                w_wake = 32'd0;
                w_runv = 1'b0;
                w_pin  = it.pin;
                res_st = tsrr_pkg::STAT_DONE;
                res_ch = it.slot;
              end
            end
            tsrr_pkg::ACT_REAP: begin
              if ((r_st == tsrr_pkg::SS_DEAD) && !r_runv) begin
                we     = 1'b1;
                w_st   = tsrr_pkg::SS_FREE;
                w_wake = 32'd0;
                w_pin  = tsrr_pkg::PIN_ANY;
                res_st = tsrr_pkg::STAT_DONE;
                res_ch = it.slot;
              end
            end
            tsrr_pkg::ACT_ADOPT: begin
              if (may_run) begin
                we     = 1'b1;
                w_st   = tsrr_pkg::SS_RUNNING;
                w_runv = 1'b1;
                w_runc = ci;
                cur_we = 1'b1;
                cur_wi = slot_i;
                res_st = tsrr_pkg::STAT_SWITCHED;
                res_ch = it.slot;
                res_pr = cur_vc ? 4'(cur_sc) : 4'd0;
              end
            end
            tsrr_pkg::ACT_SLEEP: begin
              if (cur_vc && (r_st == tsrr_pkg::SS_RUNNING)) res_load = 1'b0;
            end
            tsrr_pkg::ACT_EXIT: begin
              if (cur_vc && (r_st == tsrr_pkg::SS_RUNNING)) begin
                res_load = 1'b0;
                we       = 1'b1;
                w_st     = tsrr_pkg::SS_DEAD;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      tsrr_pkg::PH_SLEEP_WR: begin
        we     = 1'b1;
        w_st   = tsrr_pkg::SS_SLEEPING;
        w_wake = last_now + div_q + 32'(div_fix);
      end
      tsrr_pkg::PH_SCAN: begin
        if (may_run && self_hit) begin
          res_load = 1'b1;
          res_st   = tsrr_pkg::STAT_NONE;
          res_ch   = prev_out;
          res_pr   = prev_out;
        end else if (may_run) begin
          we       = 1'b1;
          w_st     = tsrr_pkg::SS_RUNNING;
          w_runv   = 1'b1;
          w_runc   = ci;
          cur_we   = 1'b1;
          cur_wi   = scan_i;
          res_load = 1'b1;
          res_st   = tsrr_pkg::STAT_SWITCHED;
          res_ch   = 4'(scan_i);
          res_pr   = prev_out;
        end else if (last_step) begin
          res_load = 1'b1;
          res_st   = tsrr_pkg::STAT_NONE;
          res_ch   = prev_out;
          res_pr   = prev_out;
        end
      end
      tsrr_pkg::PH_RELEASE: begin
        // old current slot leaves the cpu
        we     = 1'b1;
        w_st   = (r_st == tsrr_pkg::SS_RUNNING) ? tsrr_pkg::SS_READY : r_st;
        w_runv = 1'b0;
      end
      tsrr_pkg::PH_TICK: begin
        if (wake_hit) begin
          we   = 1'b1;
          w_st = tsrr_pkg::SS_READY;
        end
        if (last_step) begin
          res_load = 1'b1;
          res_st   = tsrr_pkg::STAT_DONE;
          res_wk   = 5'(woken + NW'(wake_hit));
        end
      end
      default: pop = 1'b0;
    endcase
  end

  // slot table and current slots
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREAD_SLOTS; i++) begin
        st_tab[i]   <= tsrr_pkg::SS_FREE;
        wake_tab[i] <= 32'd0;
        runv_tab[i] <= 1'b0;
        runc_tab[i] <= '0;
        pin_tab[i]  <= tsrr_pkg::PIN_ANY;
      end
      for (int c = 0; c < CPU_COUNT; c++) begin
        cur_v[c]   <= 1'b0;
        cur_idx[c] <= '0;
      end
    end else begin
      if (we) begin
        st_tab[rd_a]   <= w_st;
        wake_tab[rd_a] <= w_wake;
        runv_tab[rd_a] <= w_runv;
        runc_tab[rd_a] <= w_runc;
        pin_tab[rd_a]  <= w_pin;
      end
      if (cur_we) begin
        cur_v[ci]   <= 1'b1;
        cur_idx[ci] <= cur_wi;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tsrr_pkg::PH_IDLE;
      last_now  <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if ((phase == tsrr_pkg::PH_DECODE) && !it.rej && (it.act == tsrr_pkg::ACT_TICK)) begin
        last_now <= it.now;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, scan and divider datapath
  always_ff @(posedge clk) begin
    if (pop) it <= q_item;
    if (res_load) begin
      res_status    <= res_st;
      chosen_slot   <= res_ch;
      previous_slot <= res_pr;
      woken_count   <= res_wk;
    end
    unique case (phase)
      tsrr_pkg::PH_DECODE: begin
        prev_v <= cur_vc;
        prev_s <= cur_sc;
        scan_i <= (it.act == tsrr_pkg::ACT_TICK) ? '0 : start_i;
        scan_n <= '0;
        woken  <= '0;
      end
      tsrr_pkg::PH_MUL: begin
        div_x <= {1'b0, prod} + tsrr_pkg::ROUND_UP;
        div_q <= 32'd0;
      end
      tsrr_pkg::PH_DIV: begin
        // x := 24 * h + l, quotient gains h
        div_q <= div_q + div_h[31:0];
        div_x <= tsrr_pkg::DIV_N_W'({div_h, 4'b0000}) + tsrr_pkg::DIV_N_W'({div_h, 3'b000}) +
                 tsrr_pkg::DIV_N_W'(div_x[tsrr_pkg::DIV_SH-1:0]);
      end
      tsrr_pkg::PH_SCAN, tsrr_pkg::PH_TICK: begin
        scan_i <= (scan_i == LAST) ? '0 : scan_i + 1'b1;
        scan_n <= scan_n + 1'b1;
        woken  <= woken + NW'(wake_hit && (phase == tsrr_pkg::PH_TICK));
      end
      default: begin
        scan_n <= scan_n;
      end
    endcase
  end

  assign status    = res_status;
  assign res_clear = (chosen_slot == 4'd0) && (previous_slot == 4'd0) && (woken_count == 5'd0);

  `TSRR_ASSERT_IMP(a_load_into_free_slot, res_load, !out_valid, "result loaded over a pending one")
  `TSRR_ASSERT_NEXT(a_pop_starts_decode, pop, phase == tsrr_pkg::PH_DECODE, "pop without decode")
  `TSRR_ASSERT_IMP(a_reject_clean, out_valid && (status == tsrr_pkg::STAT_REJECT), res_clear, "rejected result carries data")
  `TSRR_ASSERT_IMP(a_release_has_prev, phase == tsrr_pkg::PH_RELEASE, prev_v, "release with no previous slot")

endmodule

`default_nettype wire

// ----- rtl/core/thread_slot_round_robin_scheduler.sv -----
// ----------------------------------------------------------------------------
// thread_slot_round_robin_scheduler
// multi-cpu thread slot table with round-robin scheduling and cpu pinning
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   cfg       cfg_valid / cfg_ready   tick_rate_hz
//   in        in_valid / in_ready     action, cpu, slot, pin_cpu, now_tick, sleep_ms
//   out       out_valid / out_ready   status, chosen_slot, previous_slot, woken_count
//
// create, reap, adopt and rejects end in decode; adopt with a current slot adds a release
// yield and exit scan one slot per cycle, visiting at most THREAD_SLOTS slots
// tick visits every slot once
// sleep adds a multiply step, divide steps (about five quotient bits each)
// and a write step before its scan
// reset clears the whole table at once; a two-entry queue keeps input open while the back end
// works, and the back end starts the next action once the result register is empty
// ----------------------------------------------------------------------------
`default_nettype none

module thread_slot_round_robin_scheduler #(
  parameter int THREAD_SLOTS = tsrr_pkg::THREAD_SLOTS_DEF,
  parameter int CPU_COUNT    = tsrr_pkg::CPU_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tsrr_pkg::RATE_W-1:0] tick_rate_hz,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  action,
  input  wire logic [1:0]                  cpu,
  input  wire logic [3:0]                  slot,
  input  wire logic signed [2:0]           pin_cpu,
  input  wire logic [31:0]                 now_tick,
  input  wire logic [31:0]                 sleep_ms,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       status,
  output logic [3:0]                       chosen_slot,
  output logic [3:0]                       previous_slot,
  output logic [4:0]                       woken_count
);

  logic [tsrr_pkg::RATE_W-1:0] rate;
  logic                        q_valid;
  tsrr_pkg::item_t             q_item;
  logic                        pop;

  // tick rate register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= tsrr_pkg::RATE_RESET;
    end else if (cfg_valid) begin
      rate <= tick_rate_hz;
    end
  end

  tsrr_front #(
    .THREAD_SLOTS (THREAD_SLOTS),
    .CPU_COUNT    (CPU_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .cpu      (cpu),
    .slot     (slot),
    .pin_cpu  (pin_cpu),
    .now_tick (now_tick),
    .sleep_ms (sleep_ms),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop)
  );

  tsrr_back #(
    .THREAD_SLOTS (THREAD_SLOTS),
    .CPU_COUNT    (CPU_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .rate          (rate),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .chosen_slot   (chosen_slot),
    .previous_slot (previous_slot),
    .woken_count   (woken_count)
  );

endmodule

`default_nettype wire
